// ===== design/bpa_pkg.sv =====
// Buddy page allocator: shared types, field widths and codes.
// No dependencies; imported by bpa_frame_table and buddy_page_allocator_unit.
package bpa_pkg;

   localparam int DEF_NUM_FRAMES = 4096;
   localparam int DEF_MAX_ORDER  = 10;

   localparam int COUNT_W  = 13;
   localparam int PAGE_W   = 12;
   localparam int ORDER_W  = 4;
   localparam int KIND_W   = 3;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // frame kinds
   localparam logic [KIND_W-1:0] KIND_FREE     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TAIL     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_KERNEL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_USER     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd4;

   // actions
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SEED  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD       = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PAGE_W-1:0]   page_index;
      logic [ORDER_W-1:0]  block_order;
      logic                user_pages;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   granted_page;
      logic [COUNT_W-1:0]  free_count;
      logic [COUNT_W-1:0]  total_count;
   } rsp_type;

endpackage

// ===== design/buddy_page_allocator_unit.sv =====
// Buddy page allocator top level: sequencer, free-list heads, counters.
// Depends on bpa_pkg and bpa_frame_table.
//
// Usage: requests arrive on req_* (valid/ready), one result per request
// leaves on rsp_* (valid/ready). csr_we/csr_wdata write frames_in_use at any
// time; it should only change while the block is idle.
// After reset a clearing pass sweeps all NUM_FRAMES frames of the table,
// one frame per cycle; req_ready stays low meanwhile. All frames come out
// reserved, every free list empty and both counters zero.
// One request is worked at a time; req_ready is low until its result has
// been placed in the output register. The work per request is set by the
// single write port of each table memory and the one-frame-per-cycle
// sequencer. Allocate searches the orders and marks the frames of each
// split level; free marks the block and, per merge, walks a free list of
// up to NUM_FRAMES links to unlink the buddy and marks the merged block;
// add block checks each frame of the block, then marks it. Worst case is
// of the order of the whole table per request.
// If the receiver stalls, the finished result waits in the output register;
// the next request may still be taken and worked, and it holds in its final
// state until the output register frees up.
module buddy_page_allocator_unit #(
   parameter int NUM_FRAMES = bpa_pkg::DEF_NUM_FRAMES,
   parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bpa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bpa_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [bpa_pkg::COUNT_W-1:0]   csr_wdata
);
   import bpa_pkg::*;

   localparam int PW = $clog2(NUM_FRAMES);
   localparam int LW = PW + 1;                       // link: frame or null
   localparam int IW = ((PW > 15) ? PW : 15) + 2;    // frame arithmetic
   localparam int OW = ORDER_W + 1;                  // order with overrun
   localparam int HW = $clog2(MAX_ORDER + 1);
   localparam int KW = KIND_W + ORDER_W;
   localparam logic [LW-1:0] NIL_LINK = {LW{1'b1}};
   localparam logic [IW-1:0] NF       = IW'(NUM_FRAMES);
   localparam logic [OW-1:0] MAXO     = OW'(MAX_ORDER);
   localparam logic [COUNT_W-1:0] FIU_RESET = COUNT_W'(4096);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_SEARCH, S_A_POP, S_A_SPLIT, S_A_PUSH, S_A_FINISH,
      S_F_RD, S_F_CHK, S_F_ADD, S_F_MERGE, S_F_BCHK,
      S_U_STEP, S_U_WAIT, S_U_CLR, S_F_MERGED, S_F_PUSH,
      S_S_CHECK, S_S_RD, S_S_CHK, S_S_PUSH,
      S_SB_HEAD, S_SB_TAIL, S_DONE
   } state_type;

   state_type            state_ff, sb_ret_ff;
   logic [IW-1:0]        i_ff;
   logic [IW-1:0]        pfn_ff, buddy_ff, sb_pfn_ff;
   logic [OW-1:0]        ord_ff, req_ord_ff;
   logic [ORDER_W-1:0]   sb_ord_ff;
   logic [KIND_W-1:0]    sb_kind_ff;
   logic                 user_ff;
   logic [LW-1:0]        cur_ff, prev_ff;
   logic [IW-1:0]        steps_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [PAGE_W-1:0]    granted_ff;
   logic [COUNT_W-1:0]   free_ff, avail_ff, fiu_ff;
   logic [LW-1:0]        head_ff [MAX_ORDER+1];
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   // frame table ports
   logic          kw_en, lw_en;
   logic [PW-1:0] kw_addr, kr_addr, lw_addr, lr_addr;
   logic [KW-1:0] kw_data, kr_data;
   logic [LW-1:0] lw_data, lr_data;
   logic [KIND_W-1:0]  rd_kind;
   logic [ORDER_W-1:0] rd_order;

   logic [IW-1:0] lim, fiu_ext, buddy_nx, push_pfn, merged_pfn, seed_end;
   logic [LW-1:0] head_sel;

   function automatic logic [IW-1:0] ord_size(input logic [OW-1:0] o);
      return IW'(1) << o;
   endfunction

   bpa_frame_table #(.NUM_FRAMES(NUM_FRAMES)) u_table (
      .clock   (clock),
      .kw_en   (kw_en),
      .kw_addr (kw_addr),
      .kw_data (kw_data),
      .kr_addr (kr_addr),
      .kr_data (kr_data),
      .lw_en   (lw_en),
      .lw_addr (lw_addr),
      .lw_data (lw_data),
      .lr_addr (lr_addr),
      .lr_data (lr_data)
   );

   assign rd_kind  = kr_data[KW-1:ORDER_W];
   assign rd_order = kr_data[ORDER_W-1:0];

   // tracked frames: min(frames_in_use, NUM_FRAMES)
   assign fiu_ext    = IW'(fiu_ff);
   assign lim        = (fiu_ext < NF) ? fiu_ext : NF;
   assign head_sel   = (ord_ff <= MAXO) ? head_ff[ord_ff[HW-1:0]] : NIL_LINK;
   assign buddy_nx   = pfn_ff ^ ord_size(ord_ff);
   assign push_pfn   = pfn_ff + ord_size(ord_ff);
   assign merged_pfn = (buddy_ff < pfn_ff) ? buddy_ff : pfn_ff;
   assign seed_end   = pfn_ff + ord_size(ord_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // table write and read port steering
   always_comb begin
      kw_en   = 1'b0;
      kw_addr = sb_pfn_ff[PW-1:0];
      kw_data = {sb_kind_ff, sb_ord_ff};
      lw_en   = 1'b0;
      lw_addr = pfn_ff[PW-1:0];
      lw_data = NIL_LINK;
      kr_addr = pfn_ff[PW-1:0];
      lr_addr = cur_ff[PW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            kw_en   = 1'b1;
            kw_addr = i_ff[PW-1:0];
            kw_data = {KIND_RESERVED, ORDER_W'(0)};
            lw_en   = 1'b1;
            lw_addr = i_ff[PW-1:0];
         end
         S_A_SEARCH: lr_addr = head_sel[PW-1:0];
         S_A_POP:    lw_en = 1'b1;
         S_A_PUSH: begin
            lw_en   = (push_pfn < NF);
            lw_addr = push_pfn[PW-1:0];
            lw_data = head_sel;
         end
         S_F_MERGE: kr_addr = buddy_nx[PW-1:0];
         S_U_WAIT: begin
            lw_en   = (cur_ff == LW'(buddy_ff)) && (prev_ff != NIL_LINK);
            lw_addr = prev_ff[PW-1:0];
            lw_data = lr_data;
         end
         S_U_CLR: begin
            lw_en   = 1'b1;
            lw_addr = cur_ff[PW-1:0];
         end
         S_F_PUSH, S_S_PUSH: begin
            lw_en   = (pfn_ff < NF);
            lw_data = head_sel;
         end
         S_S_RD: kr_addr = pfn_ff[PW-1:0] + i_ff[PW-1:0];
         S_SB_HEAD: kw_en = (sb_pfn_ff < NF);
         S_SB_TAIL: begin
            kw_en   = (i_ff < ord_size(OW'(sb_ord_ff))) && ((sb_pfn_ff + i_ff) < lim);
            kw_addr = sb_pfn_ff[PW-1:0] + i_ff[PW-1:0];
            kw_data = {KIND_TAIL, sb_ord_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sb_ret_ff    <= S_IDLE;
         i_ff         <= '0;
         free_ff      <= '0;
         avail_ff     <= '0;
         fiu_ff       <= FIU_RESET;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= MAX_ORDER; k++) begin
            head_ff[k] <= NIL_LINK;
         end
      end else begin
         if (csr_we) begin
            fiu_ff <= csr_wdata;
         end
         // S_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               i_ff <= i_ff + IW'(1);
               if (i_ff == NF - IW'(1)) begin
                  state_ff <= S_IDLE;
               end
            end

            S_IDLE: begin
               if (req_valid) begin
                  pfn_ff     <= IW'(req_data.page_index);
                  ord_ff     <= OW'(req_data.block_order);
                  req_ord_ff <= OW'(req_data.block_order);
                  user_ff    <= req_data.user_pages;
                  granted_ff <= '0;
                  if (req_data.action == ACT_NONE) begin
                     status_ff <= ST_BAD;
                     state_ff  <= S_DONE;
                  end else if (OW'(req_data.block_order) > MAXO) begin
                     status_ff <= ST_TOO_LARGE;
                     state_ff  <= S_DONE;
                  end else if (req_data.action == ACT_ALLOC) begin
                     state_ff <= S_A_SEARCH;
                  end else if (req_data.action == ACT_FREE) begin
                     state_ff <= S_F_RD;
                  end else begin
                     state_ff <= S_S_CHECK;
                  end
               end
            end

            // ---- allocate ----
            S_A_SEARCH: begin
               if (ord_ff > MAXO) begin
                  status_ff <= ST_NO_BLOCK;
                  state_ff  <= S_DONE;
               end else if (IW'(head_sel) >= NF) begin
                  ord_ff <= ord_ff + OW'(1);
               end else begin
                  pfn_ff   <= IW'(head_sel);
                  state_ff <= S_A_POP;
               end
            end
            S_A_POP: begin
               head_ff[ord_ff[HW-1:0]] <= lr_data;
               state_ff <= S_A_SPLIT;
            end
            S_A_SPLIT: begin
               if (ord_ff > req_ord_ff) begin
                  ord_ff     <= ord_ff - OW'(1);
                  sb_pfn_ff  <= pfn_ff + ord_size(ord_ff - OW'(1));
                  sb_ord_ff  <= ORDER_W'(ord_ff - OW'(1));
                  sb_kind_ff <= KIND_FREE;
                  sb_ret_ff  <= S_A_PUSH;
               end else begin
                  sb_pfn_ff  <= pfn_ff;
                  sb_ord_ff  <= ORDER_W'(req_ord_ff);
                  sb_kind_ff <= user_ff ? KIND_USER : KIND_KERNEL;
                  sb_ret_ff  <= S_A_FINISH;
               end
               state_ff <= S_SB_HEAD;
            end
            S_A_PUSH: begin
               // upper half onto its list, then re-mark the lower half
               if (push_pfn < NF) begin
                  head_ff[ord_ff[HW-1:0]] <= LW'(push_pfn);
               end
               sb_pfn_ff  <= pfn_ff;
               sb_ord_ff  <= ORDER_W'(ord_ff);
               sb_kind_ff <= KIND_FREE;
               sb_ret_ff  <= S_A_SPLIT;
               state_ff   <= S_SB_HEAD;
            end
            S_A_FINISH: begin
               free_ff    <= free_ff - COUNT_W'(ord_size(req_ord_ff));
               granted_ff <= PAGE_W'(pfn_ff);
               status_ff  <= ST_OK;
               state_ff   <= S_DONE;
            end

            // ---- free and merge ----
            S_F_RD: begin
               if (pfn_ff >= lim) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_F_CHK;
               end
            end
            S_F_CHK: begin
               if (rd_kind != KIND_KERNEL && rd_kind != KIND_USER) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else begin
                  sb_pfn_ff  <= pfn_ff;
                  sb_ord_ff  <= ORDER_W'(ord_ff);
                  sb_kind_ff <= KIND_FREE;
                  sb_ret_ff  <= S_F_ADD;
                  state_ff   <= S_SB_HEAD;
               end
            end
            S_F_ADD: begin
               free_ff  <= free_ff + COUNT_W'(ord_size(ord_ff));
               state_ff <= S_F_MERGE;
            end
            S_F_MERGE: begin
               if (ord_ff >= MAXO || buddy_nx >= lim) begin
                  state_ff <= S_F_PUSH;
               end else begin
                  buddy_ff <= buddy_nx;
                  state_ff <= S_F_BCHK;
               end
            end
            S_F_BCHK: begin
               if (rd_kind != KIND_FREE || rd_order != ORDER_W'(ord_ff)) begin
                  state_ff <= S_F_PUSH;
               end else begin
                  cur_ff   <= head_sel;
                  prev_ff  <= NIL_LINK;
                  steps_ff <= '0;
                  state_ff <= S_U_STEP;
               end
            end
            // list walk to unlink the buddy; bounded by NUM_FRAMES steps
            S_U_STEP: begin
               if (IW'(cur_ff) >= NF || steps_ff >= NF) begin
                  state_ff <= S_F_MERGED;
               end else begin
                  state_ff <= S_U_WAIT;
               end
            end
            S_U_WAIT: begin
               if (cur_ff == LW'(buddy_ff)) begin
                  if (prev_ff == NIL_LINK) begin
                     head_ff[ord_ff[HW-1:0]] <= lr_data;
                  end
                  state_ff <= S_U_CLR;
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= lr_data;
                  steps_ff <= steps_ff + IW'(1);
                  state_ff <= S_U_STEP;
               end
            end
            S_U_CLR: begin
               state_ff <= S_F_MERGED;
            end
            S_F_MERGED: begin
               pfn_ff     <= merged_pfn;
               ord_ff     <= ord_ff + OW'(1);
               sb_pfn_ff  <= merged_pfn;
               sb_ord_ff  <= ORDER_W'(ord_ff + OW'(1));
               sb_kind_ff <= KIND_FREE;
               sb_ret_ff  <= S_F_MERGE;
               state_ff   <= S_SB_HEAD;
            end
            S_F_PUSH: begin
               if (pfn_ff < NF) begin
                  head_ff[ord_ff[HW-1:0]] <= LW'(pfn_ff);
               end
               status_ff <= ST_OK;
               state_ff  <= S_DONE;
            end

            // ---- add free block ----
            S_S_CHECK: begin
               if ((pfn_ff & (ord_size(ord_ff) - IW'(1))) != '0 || seed_end > lim) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else begin
                  i_ff     <= '0;
                  state_ff <= S_S_RD;
               end
            end
            S_S_RD: begin
               state_ff <= S_S_CHK;
            end
            S_S_CHK: begin
               if (rd_kind != KIND_RESERVED) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else if (i_ff + IW'(1) == ord_size(ord_ff)) begin
                  sb_pfn_ff  <= pfn_ff;
                  sb_ord_ff  <= ORDER_W'(ord_ff);
                  sb_kind_ff <= KIND_FREE;
                  sb_ret_ff  <= S_S_PUSH;
                  state_ff   <= S_SB_HEAD;
               end else begin
                  i_ff     <= i_ff + IW'(1);
                  state_ff <= S_S_RD;
               end
            end
            S_S_PUSH: begin
               head_ff[ord_ff[HW-1:0]] <= LW'(pfn_ff);
               free_ff   <= free_ff + COUNT_W'(ord_size(ord_ff));
               avail_ff  <= avail_ff + COUNT_W'(ord_size(ord_ff));
               status_ff <= ST_OK;
               state_ff  <= S_DONE;
            end

            // ---- block marking: head then tails, one frame a cycle ----
            S_SB_HEAD: begin
               if (sb_pfn_ff >= NF) begin
                  state_ff <= sb_ret_ff;
               end else begin
                  i_ff     <= IW'(1);
                  state_ff <= S_SB_TAIL;
               end
            end
            S_SB_TAIL: begin
               if ((i_ff < ord_size(OW'(sb_ord_ff))) && ((sb_pfn_ff + i_ff) < lim)) begin
                  i_ff <= i_ff + IW'(1);
               end else begin
                  state_ff <= sb_ret_ff;
               end
            end

            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.status        <= status_ff;
                  rsp_data_ff.granted_page  <= (status_ff == ST_OK) ? granted_ff : '0;
                  rsp_data_ff.free_count    <= free_ff;
                  rsp_data_ff.total_count   <= avail_ff;
                  state_ff                  <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== design/bpa_frame_table.sv =====
// Frame table: kind/order memory and next-link memory, one write and one
// registered read port each. Depends on bpa_pkg.
module bpa_frame_table #(
   parameter int  NUM_FRAMES = 4096,
   localparam int PW = $clog2(NUM_FRAMES),
   localparam int LW = PW + 1,
   localparam int KW = bpa_pkg::KIND_W + bpa_pkg::ORDER_W
) (
   input  logic          clock,
   input  logic          kw_en,
   input  logic [PW-1:0] kw_addr,
   input  logic [KW-1:0] kw_data,
   input  logic [PW-1:0] kr_addr,
   output logic [KW-1:0] kr_data,
   input  logic          lw_en,
   input  logic [PW-1:0] lw_addr,
   input  logic [LW-1:0] lw_data,
   input  logic [PW-1:0] lr_addr,
   output logic [LW-1:0] lr_data
);
   import bpa_pkg::*;

   logic [KW-1:0] kind_mem [NUM_FRAMES];
   logic [LW-1:0] link_mem [NUM_FRAMES];

   always_ff @(posedge clock) begin
      if (kw_en) begin
         kind_mem[kw_addr] <= kw_data;
      end
      kr_data <= kind_mem[kr_addr];
   end

   always_ff @(posedge clock) begin
      if (lw_en) begin
         link_mem[lw_addr] <= lw_data;
      end
      lr_data <= link_mem[lr_addr];
   end

endmodule
